>>> rtl/vsli_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vsli_pkg
// Shared types and constants for the volume scan layout index block.
// ----------------------------------------------------------------------------
package vsli_pkg;

   localparam int EXT_W   = 11;
   localparam int SHEET_W = 21;
   localparam int CELL_W  = 31;
   localparam int INDEX_W = 32;
   localparam logic [EXT_W-1:0] MAX_EXTENT = 11'd1024;

   typedef enum logic [1:0] {
      MODE_SLABS  = 2'd0,
      MODE_BOUST  = 2'd1,
      MODE_MORTON = 2'd2,
      MODE_HELIX  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_DEPTH  = 2'd2,
      REG_MODE   = 2'd3
   } reg_type;

   typedef struct packed {
      logic [EXT_W-1:0]   width;
      logic [EXT_W-1:0]   height;
      logic [EXT_W-1:0]   depth;
      logic [SHEET_W-1:0] sheet;
      logic [CELL_W-1:0]  cells;
      logic               zero;
      logic               pow2;
   } geom_type;

   typedef struct packed {
      mode_type mode;
      geom_type geom;
   } s1_type;

   typedef struct packed {
      mode_type          mode;
      geom_type          geom;
      logic [CELL_W-1:0] at;
   } s2_type;

   typedef struct packed {
      geom_type          geom;
      logic [CELL_W-1:0] at;
      logic [EXT_W-1:0]  slab;
   } s3_type;

   function automatic logic [EXT_W-1:0] clamp_extent(input logic [31:0] value);
      logic [EXT_W-1:0] v;
      v = value[EXT_W-1:0];
      return (v > MAX_EXTENT) ? MAX_EXTENT : v;
   endfunction

endpackage
`default_nettype wire

>>> rtl/vsli_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vsli_divider
// Pipelined restoring divider, STEP_W quotient bits per stage, side payload.
// ----------------------------------------------------------------------------
module vsli_divider #(
   parameter int NUM_W  = 32,
   parameter int DEN_W  = 31,
   parameter int STEP_W = 4,
   parameter int SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [NUM_W-1:0]  in_num,
   input  wire logic [DEN_W-1:0]  in_den,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [NUM_W-1:0]       out_quo,
   output logic [DEN_W-1:0]       out_rem,
   output logic [SIDE_W-1:0]      out_side
);

   localparam int NSTAGE = (NUM_W + STEP_W - 1) / STEP_W;
   localparam int PAD_W  = NSTAGE * STEP_W;

   logic [DEN_W-1:0]  rem_ff  [NSTAGE];
   logic [PAD_W-1:0]  num_ff  [NSTAGE];
   logic [DEN_W-1:0]  den_ff  [NSTAGE];
   logic [SIDE_W-1:0] side_ff [NSTAGE];
   logic              valid_ff[NSTAGE];

   logic [DEN_W-1:0]  rem_in  [NSTAGE];
   logic [PAD_W-1:0]  num_in  [NSTAGE];
   logic [DEN_W-1:0]  src_rem [NSTAGE];
   logic [PAD_W-1:0]  src_num [NSTAGE];
   logic [DEN_W-1:0]  src_den [NSTAGE];
   logic [SIDE_W-1:0] src_side[NSTAGE];
   logic              src_vld [NSTAGE];

   for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
      if (s == 0) begin : g_first
         assign src_rem[s]  = '0;
         assign src_num[s]  = PAD_W'(in_num);
         assign src_den[s]  = in_den;
         assign src_side[s] = in_side;
         assign src_vld[s]  = in_valid;
      end else begin : g_next
         assign src_rem[s]  = rem_ff[s-1];
         assign src_num[s]  = num_ff[s-1];
         assign src_den[s]  = den_ff[s-1];
         assign src_side[s] = side_ff[s-1];
         assign src_vld[s]  = valid_ff[s-1];
      end

      always_comb begin : p_step
         logic [DEN_W-1:0] r;
         logic [PAD_W-1:0] n;
         logic [DEN_W:0]   t;
         r = src_rem[s];
         n = src_num[s];
         t = '0;
         for (int k = 0; k < STEP_W; k++) begin
            t = {r, n[PAD_W-1]};
            n = {n[PAD_W-2:0], 1'b0};
            if (t >= {1'b0, src_den[s]}) begin
               t    = t - {1'b0, src_den[s]};
               n[0] = 1'b1;
            end
            r = t[DEN_W-1:0];
         end
         rem_in[s] = r;
         num_in[s] = n;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= src_vld[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in[s];
            num_ff[s]  <= num_in[s];
            den_ff[s]  <= src_den[s];
            side_ff[s] <= src_side[s];
         end
      end
   end

   assign out_valid = valid_ff[NSTAGE-1];
   assign out_quo   = num_ff[NSTAGE-1][NUM_W-1:0];
   assign out_rem   = rem_ff[NSTAGE-1];
   assign out_side  = side_ff[NSTAGE-1];

endmodule
`default_nettype wire

>>> rtl/vsli_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vsli_front
// Captures a request with the block geometry; forms sheet and cell counts.
// ----------------------------------------------------------------------------
module vsli_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           en,
   input  wire logic                           in_valid,
   input  wire logic [vsli_pkg::INDEX_W-1:0]   in_index,
   input  wire logic [vsli_pkg::EXT_W-1:0]     cfg_width,
   input  wire logic [vsli_pkg::EXT_W-1:0]     cfg_height,
   input  wire logic [vsli_pkg::EXT_W-1:0]     cfg_depth,
   input  wire vsli_pkg::mode_type             cfg_mode,
   output logic                                out_valid,
   output logic [vsli_pkg::INDEX_W-1:0]        out_index,
   output vsli_pkg::geom_type                  out_geom,
   output vsli_pkg::mode_type                  out_mode
);

   logic                          v0_ff, v1_ff;
   logic [vsli_pkg::INDEX_W-1:0]  idx0_ff, idx1_ff;
   vsli_pkg::geom_type            geom0_ff, geom1_ff;
   vsli_pkg::geom_type            geom0_in, geom1_in;
   vsli_pkg::mode_type            mode0_ff, mode1_ff;

   function automatic logic is_pow2(input logic [vsli_pkg::EXT_W-1:0] v);
      return (v != '0) && ((v & (v - 1'b1)) == '0);
   endfunction

   always_comb begin
      geom0_in        = '0;
      geom0_in.width  = cfg_width;
      geom0_in.height = cfg_height;
      geom0_in.depth  = cfg_depth;
      geom0_in.sheet  = vsli_pkg::SHEET_W'(22'(cfg_width) * 22'(cfg_height));
      geom0_in.zero   = (cfg_width == '0) || (cfg_height == '0) || (cfg_depth == '0);
      geom0_in.pow2   = is_pow2(cfg_width) && is_pow2(cfg_height) && is_pow2(cfg_depth);
      geom1_in        = geom0_ff;
      geom1_in.cells  = vsli_pkg::CELL_W'(32'(geom0_ff.sheet) * 32'(geom0_ff.depth));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         idx0_ff  <= in_index;
         geom0_ff <= geom0_in;
         mode0_ff <= cfg_mode;
         idx1_ff  <= idx0_ff;
         geom1_ff <= geom1_in;
         mode1_ff <= mode0_ff;
      end
   end

   assign out_valid = v1_ff;
   assign out_index = idx1_ff;
   assign out_geom  = geom1_ff;
   assign out_mode  = mode1_ff;

endmodule
`default_nettype wire

>>> rtl/vsli_place.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vsli_place
// Applies the layout to slab, row and column and holds the response register.
// ----------------------------------------------------------------------------
module vsli_place (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         en,
   input  wire logic                         in_valid,
   input  wire vsli_pkg::geom_type           in_geom,
   input  wire vsli_pkg::mode_type           in_mode,
   input  wire logic [vsli_pkg::CELL_W-1:0]  in_at,
   input  wire logic [vsli_pkg::EXT_W-1:0]   in_slab,
   input  wire logic [vsli_pkg::EXT_W-1:0]   in_row,
   input  wire logic [vsli_pkg::EXT_W-1:0]   in_col,
   input  wire logic [vsli_pkg::EXT_W-1:0]   in_hcol,
   output logic                              out_valid,
   output logic [vsli_pkg::CELL_W-1:0]       out_cell,
   output logic                              out_refused
);

   logic [vsli_pkg::EXT_W-1:0]  zs, ys, xs, bcol, brow, mx, my, mz;
   logic [vsli_pkg::CELL_W-1:0] pz_in, pz_ff, at_ff, cells_ff, cell_in, cell_ff;
   logic [21:0]                 py_in, py_ff;
   logic [vsli_pkg::EXT_W-1:0]  px_ff;
   logic                        zero_in, zero_ff, refuse_in, refuse_ff, refused_ff;
   logic                        slabs_ff, v1_ff, v2_ff;
   logic [31:0]                 sum;

   always_comb begin
      mx = '0;
      my = '0;
      mz = '0;
      for (int g = 0; g < 10; g++) begin
         mx[g] = in_at[3*g];
         my[g] = in_at[3*g+1];
         mz[g] = in_at[3*g+2];
      end
      bcol = in_row[0]  ? (in_geom.width - 11'd1 - in_col) : in_col;
      brow = in_slab[0] ? (in_geom.height - 11'd1 - in_row) : in_row;
      case (in_mode)
         vsli_pkg::MODE_BOUST: begin
            zs = in_slab;
            ys = brow;
            xs = bcol;
         end
         vsli_pkg::MODE_MORTON: begin
            zs = mz & (in_geom.depth - 11'd1);
            ys = my & (in_geom.height - 11'd1);
            xs = mx & (in_geom.width - 11'd1);
         end
         vsli_pkg::MODE_HELIX: begin
            zs = in_slab;
            ys = in_row;
            xs = in_hcol;
         end
         default: begin
            zs = in_slab;
            ys = in_row;
            xs = in_col;
         end
      endcase
      pz_in     = vsli_pkg::CELL_W'(32'(zs) * 32'(in_geom.sheet));
      py_in     = 22'(zs == zs ? 22'(ys) * 22'(in_geom.width) : '0);
      zero_in   = in_geom.zero;
      refuse_in = (in_mode == vsli_pkg::MODE_MORTON) && !in_geom.pow2;
   end

   always_comb begin
      sum = 32'(pz_ff) + 32'(py_ff) + 32'(px_ff);
      if (zero_ff) begin
         cell_in = '0;
      end else if (refuse_ff) begin
         cell_in = cells_ff;
      end else if (slabs_ff) begin
         cell_in = at_ff;
      end else begin
         cell_in = sum[vsli_pkg::CELL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pz_ff      <= pz_in;
         py_ff      <= py_in;
         px_ff      <= xs;
         at_ff      <= in_at;
         cells_ff   <= in_geom.cells;
         zero_ff    <= zero_in;
         refuse_ff  <= refuse_in;
         slabs_ff   <= (in_mode == vsli_pkg::MODE_SLABS);
         cell_ff    <= cell_in;
         refused_ff <= refuse_ff && !zero_ff;
      end
   end

   assign out_valid   = v2_ff;
   assign out_cell    = cell_ff;
   assign out_refused = refused_ff;

endmodule
`default_nettype wire

>>> rtl/volume_scan_layout_index.sv
`default_nettype none
// ----------------------------------------------------------------------------
// volume_scan_layout_index
// Maps a linear index onto a cell of a width x height x depth block.
// Path: front, wrap divider, slab divider, row and helix dividers, place stage.
// Throughput: one request per cycle; the whole pipeline stalls only while
// the response register holds an untaken result.
// Reset: synchronous; clears pipeline valids, extents to 1, mode to slabs.
// ----------------------------------------------------------------------------
module volume_scan_layout_index (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [31:0]  req_item_index,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [30:0]       rsp_cell_index,
   output logic              rsp_refused,
   input  wire logic         psel,
   input  wire logic         penable,
   input  wire logic         pwrite,
   input  wire logic [3:0]   paddr,
   input  wire logic [31:0]  pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   logic [vsli_pkg::EXT_W-1:0] width_ff, height_ff, depth_ff;
   vsli_pkg::mode_type         mode_ff;
   vsli_pkg::reg_type          reg_sel;
   logic                       wr_en, en;

   logic                        f_valid;
   logic [vsli_pkg::INDEX_W-1:0] f_index;
   vsli_pkg::geom_type          f_geom;
   vsli_pkg::mode_type          f_mode;

   vsli_pkg::s1_type            s1_in, s1_out;
   vsli_pkg::s2_type            s2_in, s2_out;
   vsli_pkg::s3_type            s3_in, s3_out;
   vsli_pkg::mode_type          s4_out;
   logic                        d1_valid, d2_valid, d3_valid, d4_valid;
   logic [vsli_pkg::INDEX_W-1:0] d1_quo;
   logic [vsli_pkg::CELL_W-1:0] d1_rem, d2_quo;
   logic [vsli_pkg::SHEET_W-1:0] d2_rem, d3_quo, d4_quo;
   logic [vsli_pkg::EXT_W-1:0]  d3_rem, d4_rem;
   logic                        out_valid;

   assign pready  = 1'b1;
   assign reg_sel = vsli_pkg::reg_type'(paddr[3:2]);
   assign wr_en   = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd1;
         height_ff <= 11'd1;
         depth_ff  <= 11'd1;
         mode_ff   <= vsli_pkg::MODE_SLABS;
      end else if (wr_en) begin
         case (reg_sel)
            vsli_pkg::REG_WIDTH:  width_ff  <= vsli_pkg::clamp_extent(pwdata);
            vsli_pkg::REG_HEIGHT: height_ff <= vsli_pkg::clamp_extent(pwdata);
            vsli_pkg::REG_DEPTH:  depth_ff  <= vsli_pkg::clamp_extent(pwdata);
            vsli_pkg::REG_MODE:   mode_ff   <= vsli_pkg::mode_type'(pwdata[1:0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         vsli_pkg::REG_WIDTH:  prdata = 32'(width_ff);
         vsli_pkg::REG_HEIGHT: prdata = 32'(height_ff);
         vsli_pkg::REG_DEPTH:  prdata = 32'(depth_ff);
         vsli_pkg::REG_MODE:   prdata = 32'(mode_ff);
         default:              prdata = '0;
      endcase
   end

   assign en        = !out_valid || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = out_valid;

   vsli_front u_front (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (req_valid && req_ready),
      .in_index   (req_item_index),
      .cfg_width  (width_ff),
      .cfg_height (height_ff),
      .cfg_depth  (depth_ff),
      .cfg_mode   (mode_ff),
      .out_valid  (f_valid),
      .out_index  (f_index),
      .out_geom   (f_geom),
      .out_mode   (f_mode)
   );

   assign s1_in.mode = f_mode;
   assign s1_in.geom = f_geom;

   vsli_divider #(
      .NUM_W (vsli_pkg::INDEX_W),
      .DEN_W (vsli_pkg::CELL_W),
      .STEP_W(4),
      .SIDE_W($bits(vsli_pkg::s1_type))
   ) u_wrap (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (f_valid),
      .in_num   (f_index),
      .in_den   (f_geom.cells),
      .in_side  (s1_in),
      .out_valid(d1_valid),
      .out_quo  (d1_quo),
      .out_rem  (d1_rem),
      .out_side (s1_out)
   );

   assign s2_in.mode = s1_out.mode;
   assign s2_in.geom = s1_out.geom;
   assign s2_in.at   = d1_rem;

   vsli_divider #(
      .NUM_W (vsli_pkg::CELL_W),
      .DEN_W (vsli_pkg::SHEET_W),
      .STEP_W(4),
      .SIDE_W($bits(vsli_pkg::s2_type))
   ) u_slab (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (d1_valid && (d1_quo == d1_quo)),
      .in_num   (d1_rem),
      .in_den   (s1_out.geom.sheet),
      .in_side  (s2_in),
      .out_valid(d2_valid),
      .out_quo  (d2_quo),
      .out_rem  (d2_rem),
      .out_side (s2_out)
   );

   assign s3_in.geom = s2_out.geom;
   assign s3_in.at   = s2_out.at;
   assign s3_in.slab = d2_quo[vsli_pkg::EXT_W-1:0];

   vsli_divider #(
      .NUM_W (vsli_pkg::SHEET_W),
      .DEN_W (vsli_pkg::EXT_W),
      .STEP_W(4),
      .SIDE_W($bits(vsli_pkg::s3_type))
   ) u_row (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (d2_valid),
      .in_num   (d2_rem),
      .in_den   (s2_out.geom.width),
      .in_side  (s3_in),
      .out_valid(d3_valid),
      .out_quo  (d3_quo),
      .out_rem  (d3_rem),
      .out_side (s3_out)
   );

   vsli_divider #(
      .NUM_W (vsli_pkg::SHEET_W),
      .DEN_W (vsli_pkg::EXT_W),
      .STEP_W(4),
      .SIDE_W($bits(vsli_pkg::mode_type))
   ) u_helix (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (d2_valid),
      .in_num   (d2_rem + vsli_pkg::SHEET_W'(d2_quo[vsli_pkg::EXT_W-1:0])),
      .in_den   (s2_out.geom.width),
      .in_side  (s2_out.mode),
      .out_valid(d4_valid),
      .out_quo  (d4_quo),
      .out_rem  (d4_rem),
      .out_side (s4_out)
   );

   vsli_place u_place (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (d3_valid && d4_valid && (d4_quo == d4_quo)),
      .in_geom    (s3_out.geom),
      .in_mode    (s4_out),
      .in_at      (s3_out.at),
      .in_slab    (s3_out.slab),
      .in_row     (d3_quo[vsli_pkg::EXT_W-1:0]),
      .in_col     (d3_rem),
      .in_hcol    (d4_rem),
      .out_valid  (out_valid),
      .out_cell   (rsp_cell_index),
      .out_refused(rsp_refused)
   );

endmodule
`default_nettype wire
